// ===== rtl/tcvi_pkg.sv =====
// Shared types, constants and helpers of the tiny CPU with vectored interrupts
`default_nettype none

package tcvi_pkg;

    localparam int REGISTER_COUNT = 16;
    localparam int VECTOR_COUNT   = 256;

    localparam int RF_AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam int VT_AW = (VECTOR_COUNT > 1) ? $clog2(VECTOR_COUNT) : 1;

    localparam logic [7:0] OP_LOAD = 8'h90;
    localparam logic [7:0] OP_ADD  = 8'h58;
    localparam logic [7:0] OP_HALT = 8'hFF;

    localparam logic [31:0] LOAD_LEN    = 32'd6;
    localparam logic [31:0] ADD_LEN     = 32'd4;
    localparam logic [31:0] UNKNOWN_LEN = 32'd1;

    typedef enum logic [1:0] {
        ACT_EXEC   = 2'd0,
        ACT_IRQ    = 2'd1,
        ACT_RET    = 2'd2,
        ACT_SETVEC = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_DONE       = 3'd0,
        ST_HALTED     = 3'd1,
        ST_UNKNOWN    = 3'd2,
        ST_BADREG     = 3'd3,
        ST_NESTED     = 3'd4,
        ST_NOHANDLER  = 3'd5,
        ST_RETREFUSED = 3'd6,
        ST_VECSET     = 3'd7
    } t_status;

    typedef struct packed {
        t_action     action;
        logic [7:0]  opcode;
        logic [7:0]  dest_index;
        logic [7:0]  src_a_index;
        logic [7:0]  src_b_index;
        logic [31:0] immediate;
        logic [7:0]  vector_number;
        logic [31:0] handler_address;
    } t_item;

    typedef struct packed {
        logic [31:0] next_ip;
        logic        zero_out;
        logic        in_handler;
        logic [31:0] written_value;
        t_status     status;
    } t_result;

    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] addr_a;
        logic [RF_AW-1:0] addr_b;
    } t_rf_rd;

    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] addr;
        logic [31:0]      data;
    } t_rf_wr;

    typedef struct packed {
        logic             en;
        logic [VT_AW-1:0] addr;
    } t_vt_rd;

    typedef struct packed {
        logic             en;
        logic [VT_AW-1:0] addr;
        logic [31:0]      data;
    } t_vt_wr;

    function automatic logic reg_ok(input logic [7:0] idx);
        return {1'b0, idx} < 9'(REGISTER_COUNT);
    endfunction

    function automatic logic vec_ok(input logic [7:0] idx);
        return {1'b0, idx} < 9'(VECTOR_COUNT);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tcvi_if.sv =====
// Valid/ready channel interfaces for instruction items and result items
`default_nettype none

interface tcvi_item_if
    import tcvi_pkg::*;
();
    logic  valid;
    logic  ready;
    t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tcvi_result_if
    import tcvi_pkg::*;
();
    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/tiny_cpu_with_vector_interrupts_unit.sv =====
// Top level: tiny CPU step unit with single-level vectored interrupts
//
//   channel   | dir | handshake          | beat
//   ----------+-----+--------------------+-------------------------------------
//   i_item    | in  | valid/ready        | action, opcode, indices, imm, vector
//   o_result  | out | valid/ready        | next_ip, flags, written value, status
//
// One beat per cycle unless the output stalls; beats pass the execute and
// output registers. The taking edge issues the register-file and
// vector-table RAM reads; the next cycle executes on the read data and
// writes back; a bypass register covers a write that lands on the same edge
// as the following read. Reset clears control state and both tables' valid
// bits. A stalled result holds in the output register; the execute stage
// then holds too, and input ready falls only while both are occupied.
`default_nettype none

module tiny_cpu_with_vector_interrupts_unit
    import tcvi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    tcvi_item_if.sink     i_item,
    tcvi_result_if.source o_result
);

    logic        r_s1_valid;
    t_item       r_s1_item;
    logic        s1_adv;
    logic        take;

    logic [31:0] r_ip;
    logic        r_zero;
    logic        r_in_int;
    logic        r_saved_frame;
    logic [31:0] r_saved_ip;
    logic        r_saved_zero;

    logic [31:0] n_ip;
    logic        n_zero;
    logic        n_in_int;
    logic        n_saved_frame;
    logic        save_frame;
    t_result     n_out;

    logic        r_out_valid;
    t_result     r_out;

    t_rf_rd      rf_rd;
    t_rf_wr      rf_wr;
    t_vt_rd      vt_rd;
    t_vt_wr      vt_wr;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] vec_addr;
    logic [31:0] sum;

    assign s1_adv       = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || s1_adv;
    assign take         = i_item.valid && i_item.ready;

    assign rf_rd.en     = take;
    assign rf_rd.addr_a = i_item.payload.src_a_index[RF_AW-1:0];
    assign rf_rd.addr_b = i_item.payload.src_b_index[RF_AW-1:0];
    assign vt_rd.en     = take;
    assign vt_rd.addr   = i_item.payload.vector_number[VT_AW-1:0];

    tcvi_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (rf_rd),
        .i_wr     (rf_wr),
        .o_data_a (op_a),
        .o_data_b (op_b)
    );

    tcvi_vectab u_vectab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (vt_rd),
        .i_wr    (vt_wr),
        .o_data  (vec_addr)
    );

    assign sum = op_a + op_b;

    always_comb begin
        n_ip          = r_ip;
        n_zero        = r_zero;
        n_in_int      = r_in_int;
        n_saved_frame = r_saved_frame;
        save_frame    = 1'b0;
        rf_wr.en      = 1'b0;
        rf_wr.addr    = r_s1_item.dest_index[RF_AW-1:0];
        rf_wr.data    = '0;
        vt_wr.en      = 1'b0;
        vt_wr.addr    = r_s1_item.vector_number[VT_AW-1:0];
        vt_wr.data    = r_s1_item.handler_address;
        n_out.status  = ST_DONE;

        unique case (r_s1_item.action)
            ACT_EXEC: begin
                unique case (r_s1_item.opcode)
                    OP_LOAD: begin
                        if (reg_ok(r_s1_item.dest_index)) begin
                            rf_wr.en   = 1'b1;
                            rf_wr.data = r_s1_item.immediate;
                        end else begin
                            n_out.status = ST_BADREG;
                        end
                        n_ip = r_ip + LOAD_LEN;
                    end
                    OP_ADD: begin
                        if (reg_ok(r_s1_item.dest_index) && reg_ok(r_s1_item.src_a_index)
                                && reg_ok(r_s1_item.src_b_index)) begin
                            rf_wr.en   = 1'b1;
                            rf_wr.data = sum;
                            n_zero     = (sum == '0);
                        end else begin
                            n_out.status = ST_BADREG;
                        end
                        n_ip = r_ip + ADD_LEN;
                    end
                    OP_HALT: begin
                        n_out.status = ST_HALTED;
                    end
                    default: begin
                        n_out.status = ST_UNKNOWN;
                        n_ip         = r_ip + UNKNOWN_LEN;
                    end
                endcase
            end
            ACT_IRQ: begin
                if (r_in_int) begin
                    n_out.status = ST_NESTED;
                end else if (!vec_ok(r_s1_item.vector_number) || vec_addr == '0) begin
                    n_out.status = ST_NOHANDLER;
                end else begin
                    save_frame    = 1'b1;
                    n_saved_frame = 1'b1;
                    n_in_int      = 1'b1;
                    n_ip          = vec_addr;
                end
            end
            ACT_RET: begin
                if (!r_in_int || !r_saved_frame) begin
                    n_out.status = ST_RETREFUSED;
                end else begin
                    n_zero        = r_saved_zero;
                    n_ip          = r_saved_ip;
                    n_saved_frame = 1'b0;
                    n_in_int      = 1'b0;
                end
            end
            ACT_SETVEC: begin
                vt_wr.en     = vec_ok(r_s1_item.vector_number);
                n_out.status = ST_VECSET;
            end
            default: begin
                n_out.status = ST_DONE;
            end
        endcase

        // commit only when the stage moves on
        rf_wr.en = rf_wr.en && s1_adv;
        vt_wr.en = vt_wr.en && s1_adv;

        n_out.next_ip       = n_ip;
        n_out.zero_out      = n_zero;
        n_out.in_handler    = n_in_int;
        n_out.written_value = rf_wr.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ip          <= '0;
            r_zero        <= 1'b0;
            r_in_int      <= 1'b0;
            r_saved_frame <= 1'b0;
        end else begin
            if (take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid   <= 1'b1;
                r_ip          <= n_ip;
                r_zero        <= n_zero;
                r_in_int      <= n_in_int;
                r_saved_frame <= n_saved_frame;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_item <= i_item.payload;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
        if (s1_adv && save_frame) begin
            r_saved_ip   <= r_ip;
            r_saved_zero <= r_zero;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

`ifndef NO_ASSERTIONS
    a_frame_tracks_handler: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_int == r_saved_frame)
        else $error("handler flag and saved frame disagree");

    a_nested_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.payload.status == ST_NESTED |-> o_result.payload.in_handler)
        else $error("nested refusal reported outside a handler");

    a_no_write_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.payload.status != ST_DONE
            |-> o_result.payload.written_value == '0)
        else $error("written value set on a step that writes no register");

    a_take_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_s1_valid)
        else $error("taken beat did not reach the execute stage");

    a_write_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_wr.en || vt_wr.en |-> s1_adv && !(rf_wr.en && vt_wr.en))
        else $error("table write outside a moving execute stage");
`endif

endmodule

`default_nettype wire

// ===== rtl/tcvi_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module tcvi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tcvi_regfile.sv =====
// Register file: two RAM copies for two read ports, valid bits and write bypass
`default_nettype none

module tcvi_regfile
    import tcvi_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_rf_rd i_rd,
    input  wire t_rf_wr i_wr,
    output logic [31:0] o_data_a,
    output logic [31:0] o_data_b
);

    logic [31:0]               ram_a;
    logic [31:0]               ram_b;
    logic [REGISTER_COUNT-1:0] r_valid;
    logic                      r_fwd_vld;
    logic [RF_AW-1:0]          r_fwd_addr;
    logic [31:0]               r_fwd_data;
    logic [RF_AW-1:0]          r_rd_a;
    logic [RF_AW-1:0]          r_rd_b;

    tcvi_ram #(.WIDTH(32), .DEPTH(REGISTER_COUNT)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd.en),
        .i_raddr (i_rd.addr_a),
        .o_rdata (ram_a)
    );

    tcvi_ram #(.WIDTH(32), .DEPTH(REGISTER_COUNT)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd.en),
        .i_raddr (i_rd.addr_b),
        .o_rdata (ram_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_fwd_vld <= 1'b0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
            r_fwd_vld          <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_a <= i_rd.addr_a;
            r_rd_b <= i_rd.addr_b;
        end
    end

    // the latest write may have landed on the edge that sampled the read
    always_comb begin
        if (r_fwd_vld && r_fwd_addr == r_rd_a) begin
            o_data_a = r_fwd_data;
        end else if (r_valid[r_rd_a]) begin
            o_data_a = ram_a;
        end else begin
            o_data_a = '0;
        end
        if (r_fwd_vld && r_fwd_addr == r_rd_b) begin
            o_data_b = r_fwd_data;
        end else if (r_valid[r_rd_b]) begin
            o_data_b = ram_b;
        end else begin
            o_data_b = '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tcvi_vectab.sv =====
// Interrupt vector table: RAM with per-entry valid bits and write bypass
`default_nettype none

module tcvi_vectab
    import tcvi_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_vt_rd i_rd,
    input  wire t_vt_wr i_wr,
    output logic [31:0] o_data
);

    logic [31:0]             ram_q;
    logic [VECTOR_COUNT-1:0] r_valid;
    logic                    r_fwd_vld;
    logic [VT_AW-1:0]        r_fwd_addr;
    logic [31:0]             r_fwd_data;
    logic [VT_AW-1:0]        r_rd_addr;

    tcvi_ram #(.WIDTH(32), .DEPTH(VECTOR_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd.en),
        .i_raddr (i_rd.addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_fwd_vld <= 1'b0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
            r_fwd_vld          <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_addr <= i_rd.addr;
        end
    end

    // unwritten entries read as zero, i.e. no handler
    always_comb begin
        if (r_fwd_vld && r_fwd_addr == r_rd_addr) begin
            o_data = r_fwd_data;
        end else if (r_valid[r_rd_addr]) begin
            o_data = ram_q;
        end else begin
            o_data = '0;
        end
    end

endmodule

`default_nettype wire

// ===== bench/tiny_cpu_with_vector_interrupts_unit_test.sv =====
// Self-checking bench for the tiny CPU step unit: random and directed steps against a predictor
`timescale 1ns / 1ps

module tiny_cpu_with_vector_interrupts_unit_test
    import tcvi_pkg::*;
();

    localparam int STEP_TARGET  = 1800;
    localparam int PHASE_LEN    = 150;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcvi_item_if   item_bus ();
    tcvi_result_if result_bus ();

    tiny_cpu_with_vector_interrupts_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Architectural state as the core should hold it
    logic [31:0] gpr [REGISTER_COUNT] = '{default: '0};
    logic [31:0] vtab [VECTOR_COUNT]  = '{default: '0};
    logic [31:0] pc          = '0;
    logic        zf          = 1'b0;
    logic        in_isr      = 1'b0;
    logic        frame_valid = 1'b0;
    logic [31:0] saved_pc    = '0;
    logic        saved_zf    = 1'b0;

    t_item      pending_steps [$];
    t_result    predicted_results [$];
    logic [7:0] armed_vectors [$];

    int steps_taken  = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    bit took_step    = 1'b0;

    function automatic bit fits_rf(input logic [7:0] idx);
        return int'(idx) < REGISTER_COUNT;
    endfunction

    function automatic t_result cpu_step(input t_item it);
        t_result     r;
        logic [31:0] sum;
        r.written_value = '0;
        r.status        = ST_DONE;
        case (it.action)
            ACT_EXEC: begin
                if (it.opcode == OP_LOAD) begin
                    if (fits_rf(it.dest_index)) begin
                        gpr[it.dest_index[RF_AW-1:0]] = it.immediate;
                        r.written_value               = it.immediate;
                    end else begin
                        r.status = ST_BADREG;
                    end
                    pc = pc + LOAD_LEN;
                end else if (it.opcode == OP_ADD) begin
                    if (fits_rf(it.dest_index) && fits_rf(it.src_a_index)
                            && fits_rf(it.src_b_index)) begin
                        sum = gpr[it.src_a_index[RF_AW-1:0]]
                            + gpr[it.src_b_index[RF_AW-1:0]];
                        gpr[it.dest_index[RF_AW-1:0]] = sum;
                        zf                            = (sum == '0);
                        r.written_value               = sum;
                    end else begin
                        r.status = ST_BADREG;
                    end
                    pc = pc + ADD_LEN;
                end else if (it.opcode == OP_HALT) begin
                    r.status = ST_HALTED;
                end else begin
                    r.status = ST_UNKNOWN;
                    pc       = pc + UNKNOWN_LEN;
                end
            end
            ACT_IRQ: begin
                if (in_isr) begin
                    r.status = ST_NESTED;
                end else if (int'(it.vector_number) >= VECTOR_COUNT
                        || vtab[it.vector_number] == '0) begin
                    r.status = ST_NOHANDLER;
                end else begin
                    saved_pc    = pc;
                    saved_zf    = zf;
                    frame_valid = 1'b1;
                    in_isr      = 1'b1;
                    pc          = vtab[it.vector_number];
                end
            end
            ACT_RET: begin
                if (!in_isr || !frame_valid) begin
                    r.status = ST_RETREFUSED;
                end else begin
                    zf          = saved_zf;
                    pc          = saved_pc;
                    frame_valid = 1'b0;
                    in_isr      = 1'b0;
                end
            end
            default: begin
                if (int'(it.vector_number) < VECTOR_COUNT)
                    vtab[it.vector_number] = it.handler_address;
                r.status = ST_VECSET;
            end
        endcase
        r.next_ip    = pc;
        r.zero_out   = zf;
        r.in_handler = in_isr;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Every field random; the shaped steps below override what matters
    function automatic t_item noise_step();
        t_item it;
        it.action          = t_action'($urandom_range(3));
        it.opcode          = 8'($urandom_range(255));
        it.dest_index      = 8'($urandom_range(255));
        it.src_a_index     = 8'($urandom_range(255));
        it.src_b_index     = 8'($urandom_range(255));
        it.immediate       = $urandom();
        it.vector_number   = 8'($urandom_range(255));
        it.handler_address = $urandom();
        return it;
    endfunction

    function automatic t_item exec_step(input logic [7:0] op, input logic [7:0] d,
                                        input logic [7:0] a, input logic [7:0] b,
                                        input logic [31:0] imm);
        t_item it;
        it             = noise_step();
        it.action      = ACT_EXEC;
        it.opcode      = op;
        it.dest_index  = d;
        it.src_a_index = a;
        it.src_b_index = b;
        it.immediate   = imm;
        return it;
    endfunction

    function automatic t_item ctl_step(input t_action act, input logic [7:0] vec,
                                       input logic [31:0] addr);
        t_item it;
        it                 = noise_step();
        it.action          = act;
        it.vector_number   = vec;
        it.handler_address = addr;
        return it;
    endfunction

    // Mostly legal register numbers, now and then anything in the byte
    function automatic logic [7:0] pick_reg();
        if ($urandom_range(99) < 88)
            return 8'($urandom_range(REGISTER_COUNT - 1));
        return 8'($urandom_range(255));
    endfunction

    function automatic t_item random_exec();
        int          roll;
        logic [7:0]  op;
        logic [31:0] imm;
        roll = $urandom_range(99);
        if (roll < 35)      op = OP_LOAD;
        else if (roll < 70) op = OP_ADD;
        else if (roll < 75) op = OP_HALT;
        else                op = 8'($urandom_range(255));
        roll = $urandom_range(99);
        if (roll < 15)      imm = '0;
        else if (roll < 22) imm = 32'hFFFF_FFFF;
        else if (roll < 27) imm = 32'd1;
        else                imm = $urandom();
        return exec_step(op, pick_reg(), pick_reg(), pick_reg(), imm);
    endfunction

    function automatic logic [7:0] pick_vector();
        if (armed_vectors.size() != 0 && $urandom_range(3) != 0)
            return armed_vectors[$urandom_range(armed_vectors.size() - 1)];
        return 8'($urandom_range(255));
    endfunction

    // Driver: present steps at the falling edge, hold a beat until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_bus.valid   <= 1'b0;
            result_bus.ready <= 1'b0;
        end else begin
            case ((steps_taken / PHASE_LEN) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            result_bus.ready <= ($urandom_range(99) >= stall_pct);
            if (!item_bus.valid || took_step) begin
                if (pending_steps.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    item_bus.valid   <= 1'b1;
                    item_bus.payload <= pending_steps[0];
                end else begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check result beats first, then predict for the step taken at this edge
    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        bit      moved;
        moved     = 1'b0;
        took_step = 1'b0;
        if (i_rst_n) begin
            if (result_bus.valid && result_bus.ready) begin
                moved = 1'b1;
                got   = result_bus.payload;
                if (predicted_results.size() == 0) begin
                    $display("%t: unexpected result beat, expected none, actual %p",
                             $time, got);
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("next_ip", want.next_ip, got.next_ip);
                    compare_field("zero_out", 32'(want.zero_out), 32'(got.zero_out));
                    compare_field("in_handler", 32'(want.in_handler), 32'(got.in_handler));
                    compare_field("written_value", want.written_value, got.written_value);
                    compare_field("status", 32'(want.status), 32'(got.status));
                end
            end
            if (item_bus.valid && item_bus.ready) begin
                moved     = 1'b1;
                took_step = 1'b1;
                predicted_results.push_back(cpu_step(item_bus.payload));
                void'(pending_steps.pop_front());
                steps_taken++;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("%t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int          roll;
        int          burst;
        logic [7:0]  vec;
        logic [31:0] addr;
        i_rst_n             = 1'b0;
        item_bus.valid      = 1'b0;
        item_bus.payload    = '0;
        result_bus.ready    = 1'b0;

        // Directed: refusals at reset, register edge cases, wrap inside a handler
        pending_steps.push_back(ctl_step(ACT_RET, 8'd0, 32'd0));
        pending_steps.push_back(ctl_step(ACT_IRQ, 8'd0, 32'd0));
        pending_steps.push_back(exec_step(OP_LOAD, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF));
        pending_steps.push_back(exec_step(OP_LOAD, 8'd15, 8'd0, 8'd0, 32'd1));
        pending_steps.push_back(exec_step(OP_ADD, 8'd1, 8'd0, 8'd15, 32'd0));
        pending_steps.push_back(exec_step(OP_ADD, 8'd2, 8'd0, 8'd0, 32'd0));
        pending_steps.push_back(exec_step(OP_LOAD, 8'd16, 8'd0, 8'd0, 32'h1234_5678));
        pending_steps.push_back(exec_step(OP_LOAD, 8'd255, 8'd0, 8'd0, 32'h1));
        pending_steps.push_back(exec_step(OP_ADD, 8'd3, 8'd0, 8'd255, 32'd0));
        pending_steps.push_back(exec_step(OP_ADD, 8'd3, 8'd16, 8'd0, 32'd0));
        pending_steps.push_back(exec_step(OP_ADD, 8'd16, 8'd1, 8'd1, 32'd0));
        pending_steps.push_back(exec_step(OP_HALT, 8'd0, 8'd0, 8'd0, 32'd0));
        pending_steps.push_back(exec_step(8'h00, 8'd0, 8'd0, 8'd0, 32'd0));
        pending_steps.push_back(ctl_step(ACT_SETVEC, 8'd255, 32'hFFFF_FFFE));
        pending_steps.push_back(ctl_step(ACT_SETVEC, 8'd0, 32'd0));
        pending_steps.push_back(ctl_step(ACT_IRQ, 8'd255, 32'd0));
        pending_steps.push_back(ctl_step(ACT_IRQ, 8'd255, 32'd0));
        pending_steps.push_back(ctl_step(ACT_SETVEC, 8'd7, 32'h0000_0100));
        pending_steps.push_back(exec_step(OP_LOAD, 8'd3, 8'd0, 8'd0, 32'd0));
        pending_steps.push_back(exec_step(OP_ADD, 8'd4, 8'd3, 8'd3, 32'd0));
        pending_steps.push_back(ctl_step(ACT_RET, 8'd0, 32'd0));
        pending_steps.push_back(ctl_step(ACT_RET, 8'd0, 32'd0));
        pending_steps.push_back(ctl_step(ACT_IRQ, 8'd7, 32'd0));
        pending_steps.push_back(ctl_step(ACT_RET, 8'd0, 32'd0));
        pending_steps.push_back(ctl_step(ACT_SETVEC, 8'd7, 32'd0));
        pending_steps.push_back(ctl_step(ACT_IRQ, 8'd7, 32'd0));
        pending_steps.push_back(exec_step(8'hFE, 8'd0, 8'd0, 8'd0, 32'd0));

        // Random: handler visits around plain steps, with some noise
        while (pending_steps.size() < STEP_TARGET) begin
            roll = $urandom_range(99);
            if (armed_vectors.size() != 0 && roll < 15) begin
                pending_steps.push_back(ctl_step(ACT_IRQ,
                    armed_vectors[$urandom_range(armed_vectors.size() - 1)], $urandom()));
                burst = $urandom_range(1, 5);
                repeat (burst) pending_steps.push_back(random_exec());
                // leave a handler open now and then to provoke nesting
                if ($urandom_range(9) != 0)
                    pending_steps.push_back(ctl_step(ACT_RET, 8'($urandom_range(255)),
                                                     $urandom()));
            end else if (roll < 55) begin
                pending_steps.push_back(random_exec());
            end else if (roll < 65) begin
                pending_steps.push_back(ctl_step(ACT_IRQ, pick_vector(), $urandom()));
            end else if (roll < 73) begin
                pending_steps.push_back(ctl_step(ACT_RET, 8'($urandom_range(255)),
                                                 $urandom()));
            end else if (roll < 88) begin
                vec  = ($urandom_range(99) < 60) ? 8'($urandom_range(15))
                                                 : 8'($urandom_range(255));
                roll = $urandom_range(99);
                if (roll < 10)      addr = '0;
                else if (roll < 20) addr = 32'hFFFF_FFF0 | 32'($urandom_range(15));
                else                addr = $urandom();
                if (addr != '0)
                    armed_vectors.push_back(vec);
                pending_steps.push_back(ctl_step(ACT_SETVEC, vec, addr));
            end else begin
                pending_steps.push_back(noise_step());
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_steps.size() != 0 || predicted_results.size() != 0)
            @(posedge i_clk);
        // let any stray beat show itself
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tcvi_pkg.sv
rtl/tcvi_if.sv
rtl/tcvi_ram.sv
rtl/tcvi_regfile.sv
rtl/tcvi_vectab.sv
rtl/tiny_cpu_with_vector_interrupts_unit.sv
bench/tiny_cpu_with_vector_interrupts_unit_test.sv
